### sv/weighted_parsimony_tree_scorer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted parsimony tree scorer
// Shared forms for concurrent checks, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PARSIMONY_TREE_SCORER_UNIT_ASSERT_SVH
`define WEIGHTED_PARSIMONY_TREE_SCORER_UNIT_ASSERT_SVH

// same-cycle implication
`define WPTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wpts_pkg.sv
// ----------------------------------------------------------------------------
// wpts_pkg
// Types, constants and cost arithmetic of the weighted parsimony tree scorer
// ----------------------------------------------------------------------------
`default_nettype none
package wpts_pkg;

  localparam int STATE_SLOTS = 16;
  localparam int STATE_W     = 4;
  localparam int MAX_TIPS    = 32;
  localparam int COST_WIDTH  = 16;
  localparam int SCORE_W     = 24;
  localparam int NODE_W      = 6;
  localparam int NODE_SLOTS  = 63;
  localparam int ORDER_SLOTS = 31;
  localparam int ORDER_W     = 5;
  localparam int NC_DEPTH    = NODE_SLOTS * STATE_SLOTS;
  localparam int NC_AW       = 10;
  localparam int MAT_DEPTH   = STATE_SLOTS * STATE_SLOTS;
  localparam int MAT_AW      = 8;
  localparam int TBL_W       = 3 * NODE_W;

  localparam logic [SCORE_W-1:0] COST_INF  = {SCORE_W{1'b1}};
  localparam logic [NODE_W-1:0]  NODE_NONE = {NODE_W{1'b1}};

  // input function codes
  localparam logic [2:0] FN_MATRIX = 3'd0;
  localparam logic [2:0] FN_TIP    = 3'd1;
  localparam logic [2:0] FN_NODE   = 3'd2;
  localparam logic [2:0] FN_DOWN   = 3'd3;
  localparam logic [2:0] FN_UP     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_STATE_COUNT    = 2'd0;
  localparam logic [1:0] CFG_TIP_COUNT      = 2'd1;
  localparam logic [1:0] CFG_INTERNAL_COUNT = 2'd2;
  localparam logic [1:0] CFG_FORCED_ROOT    = 2'd3;

  // result kinds
  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_STATE = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE        = 4'd0,
    OP_NODE_LATCH  = 4'd1,
    OP_PAIR_RD     = 4'd2,
    OP_PAIR_EX     = 4'd3,
    OP_SUM         = 4'd4,
    OP_RES_WR      = 4'd5,
    OP_ROOT_LATCH  = 4'd6,
    OP_SCAN_RD     = 4'd7,
    OP_SCAN_EX     = 4'd8,
    OP_ROOT_WR     = 4'd9,
    OP_PS_RD       = 4'd10,
    OP_PS_LATCH    = 4'd11,
    OP_CHILD_WR    = 4'd12,
    OP_EMIT_SCORE  = 4'd13,
    OP_EMIT_RD     = 4'd14,
    OP_EMIT_NODE   = 4'd15
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic               up;
    logic               k;
    logic [STATE_W-1:0] s;
    logic [STATE_W-1:0] t;
    logic [ORDER_W-1:0] i;
    logic [NODE_W-1:0]  n;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // saturating cost sum, all ones is infinite
  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || sum >= {1'b0, COST_INF}) begin
      return COST_INF;
    end
    return sum[SCORE_W-1:0];
  endfunction

  // widen an input cost, all ones of the cost width is infinite
  function automatic logic [SCORE_W-1:0] cost_in(input logic [15:0] v);
    logic [15:0] m;
    logic [15:0] x;
    m = 16'((32'd1 << COST_WIDTH) - 32'd1);
    x = v & m;
    if (x == m) begin
      return COST_INF;
    end
    return {{(SCORE_W-16){1'b0}}, x};
  endfunction

endpackage
`default_nettype wire

### sv/wpts_ram.sv
// ----------------------------------------------------------------------------
// wpts_ram
// Generic single write port RAM with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module wpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/wpts_dpath.sv
// ----------------------------------------------------------------------------
// wpts_dpath
// Stores, cost arithmetic and result register of the tree scorer
// ----------------------------------------------------------------------------
`default_nettype none
module wpts_dpath
  import wpts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  input  wire logic                     in_fire,
  input  wire logic [2:0]               func,
  input  wire logic [3:0]               matrix_row,
  input  wire logic [3:0]               matrix_col,
  input  wire logic [4:0]               tip_number,
  input  wire logic [4:0]               order_position,
  input  wire logic [5:0]               node_number,
  input  wire logic [5:0]               left_child,
  input  wire logic [5:0]               right_child,
  input  wire logic [15:0]              cost_value,
  input  wire logic                     fr_valid,
  input  wire logic [STATE_W-1:0]       fr_state,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [39:0]                   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  // store ports
  logic               mat_we;
  logic [MAT_AW-1:0]  mat_waddr, mat_raddr;
  logic [SCORE_W-1:0] mat_wdata, mat_rd;
  logic               nc_we;
  logic [NC_AW-1:0]   nc_waddr, nc_raddr;
  logic [SCORE_W-1:0] nc_wdata, nc_rd;
  logic               tbl_we;
  logic [TBL_W-1:0]   tbl_wdata, tbl_rd;
  logic               asg_we;
  logic [NODE_W-1:0]  asg_waddr, asg_raddr;
  logic [STATE_W-1:0] asg_wdata, asg_rd;

  // working registers
  logic [NODE_W-1:0]  nd_r, c1_r, c2_r, root_r;
  logic [STATE_W-1:0] ps_r, bs_r, rs_r;
  logic [SCORE_W-1:0] b1_r, b2_r, best_r, score_r;
  logic [SCORE_W-1:0] res_r [STATE_SLOTS];

  logic               out_valid_r;
  logic               out_kind_r, out_last_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [NODE_W-1:0]  out_node_r;
  logic [STATE_W-1:0] out_state_r;

  logic [NODE_W-1:0]  child;
  logic [SCORE_W-1:0] child_cost, root_cost, pair_v;
  logic [STATE_W-1:0] mat_row;

  // selected child and pair cost
  always_comb begin
    child      = cmd.k ? c2_r : c1_r;
    child_cost = (child == NODE_NONE) ? COST_INF : nc_rd;
    root_cost  = (root_r == NODE_NONE) ? COST_INF : nc_rd;
    pair_v     = sat_add(mat_rd, child_cost);
    mat_row    = cmd.up ? ps_r : cmd.s;
  end

  // store addressing
  always_comb begin
    mat_we    = in_fire && (func == FN_MATRIX);
    mat_waddr = {matrix_row, matrix_col};
    mat_wdata = cost_in(cost_value);
    mat_raddr = {mat_row, cmd.t};

    if (cmd.op == OP_RES_WR) begin
      nc_we    = (nd_r != NODE_NONE);
      nc_waddr = {nd_r, cmd.s};
      nc_wdata = res_r[cmd.s];
    end else begin
      nc_we    = in_fire && (func == FN_TIP);
      nc_waddr = {1'b0, tip_number, matrix_col};
      nc_wdata = cost_in(cost_value);
    end
    nc_raddr = (cmd.op == OP_SCAN_RD) ? {root_r, cmd.s} : {child, cmd.t};

    tbl_we    = in_fire && (func == FN_NODE) && (order_position != 5'(ORDER_SLOTS));
    tbl_wdata = {right_child, left_child, node_number};

    if (cmd.op == OP_ROOT_WR) begin
      asg_we    = (root_r != NODE_NONE);
      asg_waddr = root_r;
      asg_wdata = rs_r;
    end else begin
      asg_we    = (cmd.op == OP_CHILD_WR) && (child != NODE_NONE);
      asg_waddr = child;
      asg_wdata = bs_r;
    end
    asg_raddr = (cmd.op == OP_PS_RD) ? nd_r : cmd.n;
  end

  wpts_ram #(.WIDTH(SCORE_W), .DEPTH(MAT_DEPTH)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(mat_rd)
  );

  wpts_ram #(.WIDTH(SCORE_W), .DEPTH(NC_DEPTH)) u_nc (
    .clk(clk), .we(nc_we), .waddr(nc_waddr), .wdata(nc_wdata),
    .raddr(nc_raddr), .rdata(nc_rd)
  );

  wpts_ram #(.WIDTH(TBL_W), .DEPTH(ORDER_SLOTS)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(order_position), .wdata(tbl_wdata),
    .raddr(cmd.i), .rdata(tbl_rd)
  );

  wpts_ram #(.WIDTH(STATE_W), .DEPTH(NODE_SLOTS)) u_asg (
    .clk(clk), .we(asg_we), .waddr(asg_waddr), .wdata(asg_wdata),
    .raddr(asg_raddr), .rdata(asg_rd)
  );

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_NODE_LATCH: begin
        nd_r <= tbl_rd[NODE_W-1:0];
        c1_r <= tbl_rd[2*NODE_W-1:NODE_W];
        c2_r <= tbl_rd[3*NODE_W-1:2*NODE_W];
        b1_r <= COST_INF;
        b2_r <= COST_INF;
      end
      OP_PAIR_EX: begin
        if (cmd.up) begin
          if (cmd.t == '0 || pair_v < best_r) begin
            best_r <= pair_v;
            bs_r   <= cmd.t;
          end
        end else if (!cmd.k) begin
          if (pair_v < b1_r) b1_r <= pair_v;
        end else begin
          if (pair_v < b2_r) b2_r <= pair_v;
        end
      end
      OP_SUM: begin
        res_r[cmd.s] <= sat_add(b1_r, b2_r);
        b1_r         <= COST_INF;
        b2_r         <= COST_INF;
      end
      OP_ROOT_LATCH: begin
        root_r  <= tbl_rd[NODE_W-1:0];
        score_r <= COST_INF;
        rs_r    <= '0;
      end
      OP_SCAN_EX: begin
        if (fr_valid ? (cmd.s == fr_state) : (root_cost < score_r)) begin
          score_r <= root_cost;
          rs_r    <= cmd.s;
        end
      end
      OP_PS_LATCH: begin
        ps_r <= (nd_r == NODE_NONE) ? '0 : asg_rd;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT_SCORE || cmd.op == OP_EMIT_NODE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT_SCORE) begin
      out_kind_r  <= KIND_SCORE;
      out_score_r <= score_r;
      out_node_r  <= root_r;
      out_state_r <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd.op == OP_EMIT_NODE) begin
      out_kind_r  <= KIND_STATE;
      out_score_r <= '0;
      out_node_r  <= cmd.n;
      out_state_r <= asg_rd;
      out_last_r  <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'b0, out_state_r, out_node_r, out_score_r};
  assign out_tuser    = out_kind_r;
  assign out_tlast    = out_last_r;

endmodule
`default_nettype wire

### sv/wpts_ctrl.sv
// ----------------------------------------------------------------------------
// wpts_ctrl
// Sequencer for loads, the downpass, the root scan and the uppass
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_parsimony_tree_scorer_unit_assert.svh"
module wpts_ctrl
  import wpts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [2:0]         func,
  output logic                    in_ready,
  input  wire logic [STATE_W-1:0] ns_m1,
  input  wire logic [ORDER_W-1:0] ic_m1,
  input  wire logic [NODE_W-1:0]  nodes_m1,
  output cmd_t                    cmd,
  input  wire sts_t               sts
);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DTBL  = 20'h00002,
    S_DLAT  = 20'h00004,
    S_DRD   = 20'h00008,
    S_DEX   = 20'h00010,
    S_DSUM  = 20'h00020,
    S_DWR   = 20'h00040,
    S_RTBL  = 20'h00080,
    S_RLAT  = 20'h00100,
    S_SRD   = 20'h00200,
    S_SEX   = 20'h00400,
    S_DOUT  = 20'h00800,
    S_UROOT = 20'h01000,
    S_UTBL  = 20'h02000,
    S_ULAT  = 20'h04000,
    S_UPRD  = 20'h08000,
    S_UPLAT = 20'h10000,
    S_UEX   = 20'h20000,
    S_UCWR  = 20'h40000,
    S_EOUT  = 20'h80000
  } state_t;

  // uppass pair read and emit read reuse shared states via flags
  state_t             state_r, state_nxt;
  logic               up_r, up_nxt;
  logic               rd_r, rd_nxt;
  logic               k_r, k_nxt;
  logic [STATE_W-1:0] s_r, s_nxt, t_r, t_nxt;
  logic [ORDER_W-1:0] i_r, i_nxt;
  logic [NODE_W-1:0]  n_r, n_nxt;
  dp_op_t             op;

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    up_nxt    = up_r;
    rd_nxt    = 1'b0;
    k_nxt     = k_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    op        = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_fire && func == FN_DOWN) begin
          up_nxt    = 1'b0;
          i_nxt     = '0;
          state_nxt = S_DTBL;
        end else if (in_fire && func == FN_UP) begin
          up_nxt    = 1'b1;
          i_nxt     = ic_m1;
          state_nxt = S_RTBL;
        end
      end
      S_DTBL: state_nxt = S_DLAT;
      S_DLAT: begin
        op        = OP_NODE_LATCH;
        s_nxt     = '0;
        t_nxt     = '0;
        k_nxt     = 1'b0;
        state_nxt = S_DRD;
      end
      S_DRD: begin
        op        = OP_PAIR_RD;
        state_nxt = S_DEX;
      end
      S_DEX: begin
        op = OP_PAIR_EX;
        if (!k_r) begin
          k_nxt     = 1'b1;
          state_nxt = S_DRD;
        end else begin
          k_nxt = 1'b0;
          if (t_r == ns_m1) begin
            state_nxt = S_DSUM;
          end else begin
            t_nxt     = t_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      S_DSUM: begin
        op    = OP_SUM;
        t_nxt = '0;
        if (s_r == ns_m1) begin
          s_nxt     = '0;
          state_nxt = S_DWR;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = S_DRD;
        end
      end
      S_DWR: begin
        op = OP_RES_WR;
        if (s_r == ns_m1) begin
          if (i_r == ic_m1) begin
            state_nxt = S_RTBL;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_DTBL;
          end
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      S_RTBL: state_nxt = S_RLAT;
      S_RLAT: begin
        op        = OP_ROOT_LATCH;
        s_nxt     = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        op        = OP_SCAN_RD;
        state_nxt = S_SEX;
      end
      S_SEX: begin
        op = OP_SCAN_EX;
        if (s_r == ns_m1) begin
          state_nxt = up_r ? S_UROOT : S_DOUT;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_DOUT: begin
        if (sts.out_free) begin
          op        = OP_EMIT_SCORE;
          state_nxt = S_IDLE;
        end
      end
      S_UROOT: begin
        op        = OP_ROOT_WR;
        i_nxt     = ic_m1;
        state_nxt = S_UTBL;
      end
      S_UTBL: state_nxt = S_ULAT;
      S_ULAT: begin
        op        = OP_NODE_LATCH;
        state_nxt = S_UPRD;
      end
      S_UPRD: begin
        op        = OP_PS_RD;
        state_nxt = S_UPLAT;
      end
      S_UPLAT: begin
        op        = OP_PS_LATCH;
        t_nxt     = '0;
        k_nxt     = 1'b0;
        rd_nxt    = 1'b1;
        state_nxt = S_UEX;
      end
      S_UEX: begin
        if (rd_r) begin
          op = OP_PAIR_RD;
        end else begin
          op = OP_PAIR_EX;
          if (t_r == ns_m1) begin
            state_nxt = S_UCWR;
          end else begin
            t_nxt  = t_r + 1'b1;
            rd_nxt = 1'b1;
          end
        end
      end
      S_UCWR: begin
        op    = OP_CHILD_WR;
        t_nxt = '0;
        if (!k_r) begin
          k_nxt     = 1'b1;
          rd_nxt    = 1'b1;
          state_nxt = S_UEX;
        end else begin
          k_nxt = 1'b0;
          if (i_r == '0) begin
            n_nxt     = '0;
            rd_nxt    = 1'b1;
            state_nxt = S_EOUT;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_UTBL;
          end
        end
      end
      S_EOUT: begin
        if (rd_r) begin
          op = OP_EMIT_RD;
        end else if (sts.out_free) begin
          op = OP_EMIT_NODE;
          if (n_r == nodes_m1) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt  = n_r + 1'b1;
            rd_nxt = 1'b1;
          end
        end else begin
          op = OP_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      up_r    <= 1'b0;
      rd_r    <= 1'b0;
      k_r     <= 1'b0;
      s_r     <= '0;
      t_r     <= '0;
      i_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      up_r    <= up_nxt;
      rd_r    <= rd_nxt;
      k_r     <= k_nxt;
      s_r     <= s_nxt;
      t_r     <= t_nxt;
      i_r     <= i_nxt;
      n_r     <= n_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cmd.op   = op;
  assign cmd.up   = up_r;
  assign cmd.k    = k_r;
  assign cmd.s    = s_r;
  assign cmd.t    = t_r;
  assign cmd.i    = i_r;
  assign cmd.n    = n_r;
  assign cmd.last = (n_r == nodes_m1);

  // checks on the sequencing
  `WPTS_ASSERT_NEXT(a_emit_hold, (state_r == S_EOUT && !rd_r && !sts.out_free), (n_r == $past(n_r) && state_r == S_EOUT), "node index moved while result stalled")
  `WPTS_ASSERT_NEXT(a_sum_wrap, (state_r == S_DSUM && s_r == ns_m1), (state_r == S_DWR && s_r == '0), "state sum did not start write sweep")
  `WPTS_ASSERT_NOW(a_t_range, (state_r == S_DEX || state_r == S_UEX), (t_r <= ns_m1), "state index past state count")
  `WPTS_ASSERT_NEXT(a_score_once, (state_r == S_DOUT && sts.out_free), (state_r == S_IDLE), "score result not closing the run")

endmodule
`default_nettype wire

### sv/weighted_parsimony_tree_scorer_unit.sv
// ----------------------------------------------------------------------------
// weighted_parsimony_tree_scorer_unit
// Sankoff weighted parsimony scorer: downpass root score and uppass states
// ----------------------------------------------------------------------------
// channel | direction | handshake            | content
// in_     | in        | in_tvalid/in_tready  | loads and pass starts, func in tuser
// out_    | out       | out_tvalid/out_tready| root score or node state, tlast ends run
// cfg_    | in        | cfg_we               | four registers, no read-back
//
// the pace of the downpass and uppass is set by the single read port of the node
// cost memory, one child cost per read and compare step.
// reset (rst_n low, synchronous) clears control only; stores are undefined until written.
// out_tready low stalls result emission; in_tready is high only between runs.
// ----------------------------------------------------------------------------
`default_nettype none
module weighted_parsimony_tree_scorer_unit
  import wpts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // matrix_row, matrix_col, tip_number,
                                       // order_position, node_number, left_child,
                                       // right_child, cost_value, zero pad
  input  wire logic [2:0]  in_tuser,   // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // score, result_node, node_state, zero pad
  output logic             out_tuser,  // kind
  output logic             out_tlast,  // last
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_wdata
);

  logic [4:0] state_count_r;
  logic [5:0] tip_count_r;
  logic [4:0] internal_count_r;
  logic [4:0] forced_root_r;

  logic               in_fire, in_ready;
  logic [4:0]         ns;
  logic [STATE_W-1:0] ns_m1;
  logic [ORDER_W-1:0] ic_m1;
  logic [5:0]         tips;
  logic [6:0]         nodes;
  logic [NODE_W-1:0]  nodes_m1;
  logic               fr_valid;
  cmd_t               cmd;
  sts_t               sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r    <= 5'd4;
      tip_count_r      <= 6'd32;
      internal_count_r <= 5'd31;
      forced_root_r    <= 5'h1f;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STATE_COUNT:    state_count_r    <= cfg_wdata[4:0];
        CFG_TIP_COUNT:      tip_count_r      <= cfg_wdata;
        CFG_INTERNAL_COUNT: internal_count_r <= cfg_wdata[4:0];
        CFG_FORCED_ROOT:    forced_root_r    <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // effective counts after clamping
  always_comb begin
    if (state_count_r < 5'd2) ns = 5'd2;
    else if (state_count_r > 5'(STATE_SLOTS)) ns = 5'(STATE_SLOTS);
    else ns = state_count_r;
    ns_m1 = 4'(ns - 5'd1);
    ic_m1 = (internal_count_r == '0) ? '0 : internal_count_r - 5'd1;
    if (tip_count_r < 6'd2) tips = 6'd2;
    else if (tip_count_r > 6'(MAX_TIPS)) tips = 6'(MAX_TIPS);
    else tips = tip_count_r;
    nodes = {1'b0, tips} + {2'b0, ic_m1} + 7'd1;
    if (nodes > 7'(NODE_SLOTS)) nodes = 7'(NODE_SLOTS);
    nodes_m1 = 6'(nodes - 7'd1);
    fr_valid = !forced_root_r[4] && ({1'b0, forced_root_r[3:0]} < ns);
  end

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;

  wpts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .func(in_tuser),
    .in_ready(in_ready), .ns_m1(ns_m1), .ic_m1(ic_m1), .nodes_m1(nodes_m1),
    .cmd(cmd), .sts(sts)
  );

  wpts_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_fire(in_fire),
    .func(in_tuser),
    .matrix_row(in_tdata[3:0]), .matrix_col(in_tdata[7:4]),
    .tip_number(in_tdata[12:8]), .order_position(in_tdata[17:13]),
    .node_number(in_tdata[23:18]), .left_child(in_tdata[29:24]),
    .right_child(in_tdata[35:30]), .cost_value(in_tdata[51:36]),
    .fr_valid(fr_valid), .fr_state(forced_root_r[3:0]),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted parsimony tree scorer. It loads cost
// matrices, tip costs and random binary trees, then starts downpasses and
// uppasses. A scoreboard that scores the same trees predicts the root scores
// and node states, and checks them in order against the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  logic        kind;
  logic [23:0] score;
  logic [5:0]  node;
  logic [3:0]  state;
  logic        last;
} scorer_result_t;

class parsimony_scoreboard;
  localparam logic [23:0] INF = 24'hFFFFFF;

  logic [23:0] trans[16][16];
  logic [23:0] node_cost[63][16];
  logic [5:0]  ord_node[31], ord_left[31], ord_right[31];
  logic [3:0]  node_state[63];
  logic [4:0]  reg_states, reg_internal, reg_root;
  logic [5:0]  reg_tips;

  scorer_result_t awaited[$];
  int mismatches;
  int checked;

  function new();
    reg_states   = 5'd4;
    reg_tips     = 6'd32;
    reg_internal = 5'd31;
    reg_root     = 5'h1F;
    mismatches   = 0;
    checked      = 0;
  endfunction

  function automatic logic [23:0] add_cost(logic [23:0] a, logic [23:0] b);
    logic [24:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == INF || b == INF || s >= {1'b0, INF}) return INF;
    return s[23:0];
  endfunction

  function automatic logic [23:0] cost_of(int n, int s);
    if (n >= 63) return INF;
    return node_cost[n][s];
  endfunction

  function automatic int states_used();
    int n;
    n = reg_states;
    if (n < 2) n = 2;
    if (n > 16) n = 16;
    return n;
  endfunction

  // forced root state, or -1 for free choice
  function automatic int pinned_root(int ns);
    if (reg_root[4]) return -1;
    return (reg_root < ns) ? int'(reg_root) : -1;
  endfunction

  function void write_reg(logic [1:0] idx, logic [5:0] val);
    case (idx)
      wpts_pkg::CFG_STATE_COUNT:    reg_states = val[4:0];
      wpts_pkg::CFG_TIP_COUNT:      reg_tips = val;
      wpts_pkg::CFG_INTERNAL_COUNT: reg_internal = val[4:0];
      wpts_pkg::CFG_FORCED_ROOT:    reg_root = val[4:0];
      default: ;
    endcase
  endfunction

  // accepted input item: update stores, queue the results it causes
  function void note_item(logic [2:0] func, logic [55:0] d);
    int ns, ic, tips, root, fr, nodes, ps, ch, bs;
    logic [23:0] cv, b1, b2, v, bv;
    logic [23:0] res[16];
    scorer_result_t r;
    ns = states_used();
    ic = (reg_internal < 1) ? 1 : reg_internal;
    tips = reg_tips;
    if (tips < 2) tips = 2;
    if (tips > 32) tips = 32;
    root = ord_node[ic-1];
    fr = pinned_root(ns);
    cv = (d[51:36] == 16'hFFFF) ? INF : {8'd0, d[51:36]};
    case (func)
      wpts_pkg::FN_MATRIX: trans[d[3:0]][d[7:4]] = cv;
      wpts_pkg::FN_TIP:    node_cost[d[12:8]][d[7:4]] = cv;
      wpts_pkg::FN_NODE: begin
        if (d[17:13] < 31) begin
          ord_node[d[17:13]]  = d[23:18];
          ord_left[d[17:13]]  = d[29:24];
          ord_right[d[17:13]] = d[35:30];
        end
      end
      wpts_pkg::FN_DOWN: begin
        for (int i = 0; i < ic; i++) begin
          for (int s = 0; s < ns; s++) begin
            b1 = INF;
            b2 = INF;
            for (int t = 0; t < ns; t++) begin
              v = add_cost(trans[s][t], cost_of(ord_left[i], t));
              if (v < b1) b1 = v;
              v = add_cost(trans[s][t], cost_of(ord_right[i], t));
              if (v < b2) b2 = v;
            end
            res[s] = add_cost(b1, b2);
          end
          if (ord_node[i] < 63)
            for (int s = 0; s < ns; s++) node_cost[ord_node[i]][s] = res[s];
        end
        r.kind = wpts_pkg::KIND_SCORE;
        if (fr >= 0) r.score = cost_of(root, fr);
        else begin
          r.score = INF;
          for (int s = 0; s < ns; s++)
            if (cost_of(root, s) < r.score) r.score = cost_of(root, s);
        end
        r.node = root[5:0];
        r.state = 4'd0;
        r.last = 1'b1;
        awaited.push_back(r);
      end
      wpts_pkg::FN_UP: begin
        if (fr >= 0) bs = fr;
        else begin
          bs = 0;
          bv = cost_of(root, 0);
          for (int s = 1; s < ns; s++)
            if (cost_of(root, s) < bv) begin
              bv = cost_of(root, s);
              bs = s;
            end
        end
        if (root < 63) node_state[root] = bs[3:0];
        // walk the postorder list backwards, children take their best state
        for (int i = ic - 1; i >= 0; i--) begin
          ps = (ord_node[i] < 63) ? node_state[ord_node[i]] : 0;
          for (int k = 0; k < 2; k++) begin
            ch = k ? ord_right[i] : ord_left[i];
            bs = 0;
            bv = add_cost(trans[ps][0], cost_of(ch, 0));
            for (int t = 1; t < ns; t++) begin
              v = add_cost(trans[ps][t], cost_of(ch, t));
              if (v < bv) begin
                bv = v;
                bs = t;
              end
            end
            if (ch < 63) node_state[ch] = bs[3:0];
          end
        end
        nodes = tips + ic;
        if (nodes > 63) nodes = 63;
        for (int i = 0; i < nodes; i++) begin
          r.kind = wpts_pkg::KIND_STATE;
          r.score = 24'd0;
          r.node = i[5:0];
          r.state = node_state[i];
          r.last = (i + 1 == nodes);
          awaited.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(scorer_result_t got);
    scorer_result_t want;
    checked++;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result kind=%0d score=%0h node=%0d state=%0d last=%0d",
                 got.kind, got.score, got.node, got.state, got.last);
      return;
    end
    want = awaited.pop_front();
    if (got.kind !== want.kind || got.score !== want.score || got.node !== want.node ||
        got.state !== want.state || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp kind=%0d score=%0h node=%0d state=%0d last=%0d, %s",
                 want.kind, want.score, want.node, want.state, want.last,
                 $sformatf("got %0d %0h %0d %0d %0d",
                           got.kind, got.score, got.node, got.state, got.last));
    end
  endfunction
endclass

module tb;
  import wpts_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_wdata = '0;

  parsimony_scoreboard sb = new();
  bit   bursty = 1'b1;
  int   cycles = 0;
  int   stall_left = 0;
  int   items_sent = 0;
  int   trees_scored = 0;

  weighted_parsimony_tree_scorer_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (bursty && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
    end
  end

  // result monitor
  always @(posedge clk) begin
    scorer_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.score = out_tdata[23:0];
      got.node = out_tdata[29:24];
      got.state = out_tdata[33:30];
      got.last = out_tlast;
      sb.check_result(got);
    end
  end

  function automatic logic [55:0] noise_bits();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'd0;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_item(input logic [2:0] func, input logic [55:0] d);
    if (bursty && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = func;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(func, d);
    if (func <= FN_UP) items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // an item the block ignores or that touches nothing read later
  task automatic send_noise();
    logic [55:0] d;
    d = noise_bits();
    d[55:52] = '0;
    case ($urandom_range(0, 2))
      0: send_item(3'($urandom_range(5, 7)), d);
      1: begin
        d[17:13] = 5'd31;
        send_item(FN_NODE, d);
      end
      default: send_item(3'($urandom_range(5, 7)), d);
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // configure, load a full problem with a random tree, then score it
  task automatic score_tree(input int sc_w, input int ic_w, input int tc_w, input int fr_w,
                            input bit do_up, input bit cut_child);
    int ns, ic, tips, a, b, na, nb;
    int pool[$];
    logic [55:0] d;
    ns = sc_w < 2 ? 2 : (sc_w > 16 ? 16 : sc_w);
    ic = ic_w < 1 ? 1 : ic_w;
    tips = ic + 1;
    if ((tc_w < 2 ? 2 : (tc_w > 32 ? 32 : tc_w)) != tips) tc_w = tips;
    wait_idle();
    write_reg(CFG_STATE_COUNT, 6'(sc_w));
    write_reg(CFG_TIP_COUNT, 6'(tc_w));
    write_reg(CFG_INTERNAL_COUNT, 6'(ic_w));
    write_reg(CFG_FORCED_ROOT, 6'(fr_w));
    // transition costs
    for (int r = 0; r < ns; r++)
      for (int c = 0; c < ns; c++) begin
        d = noise_bits();
        d[3:0] = r[3:0];
        d[7:4] = c[3:0];
        d[51:36] = (r == c && $urandom_range(0, 1)) ? 16'd0 : pick_cost();
        send_item(FN_MATRIX, d);
        if ($urandom_range(0, 15) == 0) send_noise();
      end
    // tip state costs
    for (int t = 0; t < tips; t++)
      for (int s = 0; s < ns; s++) begin
        d = noise_bits();
        d[7:4] = s[3:0];
        d[12:8] = t[4:0];
        d[51:36] = pick_cost();
        send_item(FN_TIP, d);
      end
    // random tree in postorder, internal nodes numbered after the tips
    for (int t = 0; t < tips; t++) pool.push_back(t);
    for (int i = 0; i < ic; i++) begin
      a = $urandom_range(0, pool.size() - 1);
      na = pool[a];
      pool.delete(a);
      b = $urandom_range(0, pool.size() - 1);
      nb = pool[b];
      pool.delete(b);
      pool.push_back(tips + i);
      d = noise_bits();
      d[17:13] = i[4:0];
      d[23:18] = 6'(tips + i);
      d[29:24] = 6'(na);
      d[35:30] = (cut_child && i == ic - 1) ? 6'd63 : 6'(nb);
      send_item(FN_NODE, d);
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    send_item(FN_DOWN, noise_bits());
    if (do_up) send_item(FN_UP, noise_bits());
    if (do_up && $urandom_range(0, 5) == 0) send_item(FN_UP, noise_bits());
    trees_scored++;
  endtask

  function automatic int pick_root(input int ns);
    case ($urandom_range(0, 3))
      0: return 31;
      1: return $urandom_range(16, 31);
      2: return $urandom_range(ns, 15);
      default: return $urandom_range(0, ns - 1);
    endcase
  endfunction

  initial begin
    int ns;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: ignored codes, smallest clamped setup, cut child, widest tree
    send_noise();
    send_noise();
    score_tree(0, 0, 0, 31, 1'b1, 1'b0);
    score_tree(2, 1, 1, 0, 1'b0, 1'b1);
    score_tree(3, 2, 3, 2, 1'b1, 1'b0);
    score_tree(2, 31, 63, 1, 1'b1, 1'b0);

    // random trees, small sizes mostly
    while (items_sent < 190) begin
      ns = $urandom_range(2, 4);
      score_tree(ns, $urandom_range(1, 6), 0, pick_root(ns), $urandom_range(0, 5) != 0,
                 $urandom_range(0, 15) == 0);
    end

    // closing stretch without random input gaps or result stalls
    bursty = 1'b0;
    repeat (3) begin
      ns = $urandom_range(2, 5);
      score_tree(ns, $urandom_range(1, 8), 0, pick_root(ns), 1'b1, 1'b0);
    end

    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("scored %0d trees from %0d input items, %0d results checked",
             trees_scored, items_sent, sb.checked);
    $display("state counts 2..5, trees of 1..31 internal nodes, forced and free roots");
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
